>>> rtl/kps_pkg.sv
// Shared types, constants and command map lookup for the keyword posterior smoother.
package kps_pkg;

    localparam int NUM_CLASSES = 16;

    localparam int CLASS_W = 4;
    localparam int PROB_W  = 16;
    localparam int CMD_W   = 3;
    localparam int MAP_W   = CMD_W * 16;
    localparam int CNT_W   = 8;
    localparam int ROW_W   = 9;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = MAP_W;

    localparam logic [CLASS_W:0] CLASS_LIMIT = (CLASS_W + 1)'(NUM_CLASSES);

    localparam logic [MAP_W-1:0]  MAP_RESET       = '0;
    localparam logic [PROB_W-1:0] ALPHA_RESET     = 16'd7864;
    localparam logic [PROB_W-1:0] THRESHOLD_RESET = 16'd52429;
    localparam logic [CNT_W-1:0]  ROW_RESET       = 8'd10;
    localparam logic [CNT_W-1:0]  LOCKOUT_RESET   = 8'd10;
    localparam logic [CNT_W-1:0]  IDLE_RESET      = 8'd25;

    localparam logic [CMD_W-1:0] CMD_NONE = 3'd0;
    localparam logic [CMD_W-1:0] CMD_MAX  = 3'd4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CLASS_MAP   = 3'd0,
        REG_EMA_ALPHA   = 3'd1,
        REG_THRESHOLD   = 3'd2,
        REG_ROW_BLOCKS  = 3'd3,
        REG_LOCKOUT     = 3'd4,
        REG_IDLE_EVERY  = 3'd5
    } cfg_reg_t;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_IDLE = 2'd1,
        KIND_FIRE = 2'd2
    } report_kind_t;

    function automatic logic [CMD_W-1:0] map_command(
        input logic [MAP_W-1:0]   cmd_map,
        input logic [CLASS_W-1:0] cls
    );
        logic [5:0]       base;
        logic [CMD_W-1:0] code;
        base = 6'(cls) * 6'd3;
        code = cmd_map[base +: CMD_W];
        if ({1'b0, cls} >= CLASS_LIMIT || code > CMD_MAX)
        begin
            return CMD_NONE;
        end
        return code;
    endfunction

endpackage

>>> rtl/keyword_posterior_smoother.sv
// Top level of the keyword posterior smoother: input stage, smoothing update and result register.
//
// Usage: one beat on the input channel carries one classifier result per audio
// block (class_index, class_probability). Each input beat produces exactly one
// result beat (report_kind, fired_command, top_command, smoothed_confidence,
// in_lockout), in order. A beat moves when valid is high and stall is low.
// Configuration registers are written through cfg_write/cfg_index/cfg_data,
// one register per cycle; the user must write them only while no item is in
// flight, as the block itself does not enforce it. An accepted item is
// captured in the input register, and its result is then loaded into the
// result register, which drives out_valid. Throughput: one item per cycle
// while the receiver does not stall. The row count and smoothed average close
// their loop through a single 17x17 multiply, add and compare between the
// input register and the result register.
// Reset clears the state, the pipeline valid bits and loads the default
// configuration. When the receiver stalls, the result register holds; the
// input register still takes one more item, after which in_stall rises.
module keyword_posterior_smoother (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [kps_pkg::CLASS_W-1:0]        class_index,
    input  logic [kps_pkg::PROB_W-1:0]         class_probability,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [1:0]                         report_kind,
    output logic [kps_pkg::CMD_W-1:0]          fired_command,
    output logic [kps_pkg::CMD_W-1:0]          top_command,
    output logic [kps_pkg::PROB_W-1:0]         smoothed_confidence,
    output logic                               in_lockout,
    input  logic                               cfg_write,
    input  logic [kps_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [kps_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import kps_pkg::*;

    logic [MAP_W-1:0]  map_reg;
    logic [PROB_W-1:0] alpha_reg;
    logic [PROB_W-1:0] threshold_reg;
    logic [CNT_W-1:0]  row_blocks_reg;
    logic [CNT_W-1:0]  lockout_reg;
    logic [CNT_W-1:0]  idle_every_reg;

    logic                    s1_valid_reg;
    logic [CLASS_W-1:0]      s1_class_reg;
    logic [PROB_W-1:0]       s1_prob_reg;
    logic [CMD_W-1:0]        s1_cmd_reg;

    logic [CLASS_W-1:0]      prev_class_reg, prev_class_next;
    logic signed [ROW_W-1:0] row_reg, row_next;
    logic [PROB_W-1:0]       avg_reg, avg_next;
    logic [CNT_W-1:0]        idle_reg, idle_next;

    logic                    out_valid_reg;
    report_kind_t            kind_reg, kind_next;
    logic [CMD_W-1:0]        fired_reg, fired_next;
    logic [CMD_W-1:0]        top_reg;
    logic [PROB_W-1:0]       shown_reg, shown_next;
    logic                    lockout_flag_reg;

    logic                    out_load;
    logic                    s1_move;
    logic                    in_take;

    logic                    is_cmd;
    logic                    same_class;
    logic signed [ROW_W-1:0] base_row;
    logic [PROB_W-1:0]       base_avg;
    logic signed [ROW_W-1:0] row_inc;
    logic signed [PROB_W:0]  diff;
    logic signed [PROB_W:0]  alpha_s;
    logic signed [33:0]      prod;
    logic signed [33:0]      acc;
    logic [PROB_W-1:0]       new_avg;
    logic                    fire;
    logic [CNT_W-1:0]        idle_inc;

    assign out_load = !out_valid_reg || !out_stall;
    assign s1_move  = s1_valid_reg && out_load;
    assign in_stall = s1_valid_reg && !out_load;
    assign in_take  = in_valid && !in_stall;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_reg        <= MAP_RESET;
            alpha_reg      <= ALPHA_RESET;
            threshold_reg  <= THRESHOLD_RESET;
            row_blocks_reg <= ROW_RESET;
            lockout_reg    <= LOCKOUT_RESET;
            idle_every_reg <= IDLE_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_CLASS_MAP:  map_reg        <= cfg_data[MAP_W-1:0];
                REG_EMA_ALPHA:  alpha_reg      <= cfg_data[PROB_W-1:0];
                REG_THRESHOLD:  threshold_reg  <= cfg_data[PROB_W-1:0];
                REG_ROW_BLOCKS: row_blocks_reg <= cfg_data[CNT_W-1:0];
                REG_LOCKOUT:    lockout_reg    <= cfg_data[CNT_W-1:0];
                REG_IDLE_EVERY: idle_every_reg <= cfg_data[CNT_W-1:0];
                default:        ;
            endcase
        end
    end

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_class_reg <= class_index;
            s1_prob_reg  <= class_probability;
            s1_cmd_reg   <= map_command(map_reg, class_index);
        end
    end

    // Smoothing update
    always_comb
    begin
        is_cmd     = (s1_cmd_reg != CMD_NONE);
        same_class = (s1_class_reg == prev_class_reg);
        base_row   = same_class ? row_reg : '0;
        base_avg   = same_class ? avg_reg : '0;
        row_inc    = (base_row != 9'sd255) ? base_row + 9'sd1 : base_row;

        alpha_s = signed'({1'b0, alpha_reg});
        diff    = signed'({1'b0, s1_prob_reg}) - signed'({1'b0, base_avg});
        prod    = alpha_s * diff;
        acc     = signed'({2'b00, base_avg, 16'h0000}) + prod;
        new_avg = acc[31:16];

        fire = is_cmd
            && (signed'({row_inc[ROW_W-1], row_inc}) >= signed'({2'b00, row_blocks_reg}))
            && (new_avg >= threshold_reg);

        prev_class_next = is_cmd ? s1_class_reg : prev_class_reg;
        if (!is_cmd)
        begin
            row_next = '0;
            avg_next = '0;
        end
        else if (fire)
        begin
            row_next = signed'(ROW_W'(0) - {1'b0, lockout_reg});
            avg_next = '0;
        end
        else
        begin
            row_next = row_inc;
            avg_next = new_avg;
        end

        shown_next = is_cmd ? new_avg : '0;
        fired_next = fire ? s1_cmd_reg : CMD_NONE;

        idle_inc = idle_reg + 8'd1;
        if (fire)
        begin
            idle_next = '0;
            kind_next = KIND_FIRE;
        end
        else if (idle_inc >= idle_every_reg)
        begin
            idle_next = '0;
            kind_next = KIND_IDLE;
        end
        else
        begin
            idle_next = idle_inc;
            kind_next = KIND_NONE;
        end
    end

    // State and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_class_reg <= '0;
            row_reg        <= '0;
            avg_reg        <= '0;
            idle_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (s1_move)
            begin
                prev_class_reg <= prev_class_next;
                row_reg        <= row_next;
                avg_reg        <= avg_next;
                idle_reg       <= idle_next;
            end
            if (out_load)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            kind_reg         <= kind_next;
            fired_reg        <= fired_next;
            top_reg          <= s1_cmd_reg;
            shown_reg        <= shown_next;
            lockout_flag_reg <= row_next[ROW_W-1];
        end
    end

    assign out_valid           = out_valid_reg;
    assign report_kind         = kind_reg;
    assign fired_command       = fired_reg;
    assign top_command         = top_reg;
    assign smoothed_confidence = shown_reg;
    assign in_lockout          = lockout_flag_reg;

endmodule

>>> rtl/kps_checker.sv
// Port-level checker for the keyword posterior smoother and its bind.
module kps_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [1:0]                    report_kind,
    input logic [kps_pkg::CMD_W-1:0]     fired_command,
    input logic [kps_pkg::CMD_W-1:0]     top_command,
    input logic [kps_pkg::PROB_W-1:0]    smoothed_confidence,
    input logic                          in_lockout
);
    import kps_pkg::*;

    a_fire_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && report_kind == KIND_FIRE)
        |-> (fired_command != CMD_NONE && fired_command == top_command))
        else $error("fired command does not match block command");

    a_no_fire_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && report_kind != KIND_FIRE) |-> (fired_command == CMD_NONE))
        else $error("fired command without fire report");

    a_background: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && top_command == CMD_NONE)
        |-> (smoothed_confidence == '0 && !in_lockout && report_kind != KIND_FIRE))
        else $error("background block carries confidence, lockout or fire");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall)
        |=> (out_valid && $stable(report_kind) && $stable(smoothed_confidence)
             && $stable(top_command)))
        else $error("stalled result beat changed");

endmodule

bind keyword_posterior_smoother kps_checker u_kps_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .report_kind         (report_kind),
    .fired_command       (fired_command),
    .top_command         (top_command),
    .smoothed_confidence (smoothed_confidence),
    .in_lockout          (in_lockout)
);

>>> tb/tb_keyword_posterior_smoother.sv
// Self-checking testbench for keyword_posterior_smoother: directed rows, random runs, stalls.
module tb_keyword_posterior_smoother;
    import kps_pkg::*;

    localparam int CLK_PERIOD      = 12;
    localparam int WATCHDOG_CYCLES = 300000;
    localparam int NUM_DIRECTED    = 40;
    localparam int PRINT_CAP       = 40;
    localparam int LONG_HOLD       = 60;

    localparam logic [CFG_IDX_W-1:0]  REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0]  REG_SPARE_HI = 3'd7;
    localparam logic [CFG_DATA_W-1:0] MAP_ALL_SET  = 48'hFFFF_FFFF_FFFF;
    // classes 1..11 take codes 1,2,3,4,5,6,7,1,2,3,4 and class 15 takes 4
    localparam logic [CFG_DATA_W-1:0] MAP_MIXED    = 48'h8008_D1FA_C688;
    localparam logic [CFG_DATA_W-1:0] MAP_ALL_RIGHT = 48'o3333_3333_3333_3333;

    typedef struct packed {
        report_kind_t       kind;
        logic [CMD_W-1:0]   fired;
        logic [CMD_W-1:0]   top;
        logic [PROB_W-1:0]  conf;
        logic               lock;
    } block_report_t;

    typedef enum logic {
        ROW_BLOCK = 1'b0,
        ROW_SETUP = 1'b1
    } row_op_t;

    typedef struct packed {
        row_op_t                op;
        logic [CFG_IDX_W-1:0]   reg_index;
        logic [CFG_DATA_W-1:0]  reg_value;
        logic [CLASS_W-1:0]     cls;
        logic [PROB_W-1:0]      prob;
        logic                   typed;
        block_report_t          want;
    } stim_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    logic [CLASS_W-1:0]     class_index;
    logic [PROB_W-1:0]      class_probability;
    logic                   out_valid;
    logic                   out_stall;
    logic [1:0]             report_kind;
    logic [CMD_W-1:0]       fired_command;
    logic [CMD_W-1:0]       top_command;
    logic [PROB_W-1:0]      smoothed_confidence;
    logic                   in_lockout;
    logic                   cfg_write;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    logic [CFG_DATA_W-1:0]  cmd_map;
    logic [PROB_W-1:0]      mix_alpha;
    logic [PROB_W-1:0]      fire_level;
    logic [CNT_W-1:0]       run_needed;
    logic [CNT_W-1:0]       lockout_len;
    logic [CNT_W-1:0]       report_every;
    logic [CLASS_W-1:0]     last_class;
    int                     run_count;
    logic [PROB_W-1:0]      avg_conf;
    logic [CNT_W-1:0]       quiet_count;

    block_report_t          expected_reports[$];
    block_report_t          want;
    stim_row_t              directed_rows [NUM_DIRECTED];
    int                     mismatches;
    int                     send_gap_pct;
    int                     drain_stall_pct;
    int                     hold_left;
    logic                   long_hold_req;
    logic                   blocks_open;

    keyword_posterior_smoother u_top (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (in_valid),
        .in_stall            (in_stall),
        .class_index         (class_index),
        .class_probability   (class_probability),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .report_kind         (report_kind),
        .fired_command       (fired_command),
        .top_command         (top_command),
        .smoothed_confidence (smoothed_confidence),
        .in_lockout          (in_lockout),
        .cfg_write           (cfg_write),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data)
    );

    function automatic block_report_t smooth_block(
        input logic [CLASS_W-1:0] cls,
        input logic [PROB_W-1:0]  prob
    );
        block_report_t    rep;
        logic [CFG_DATA_W-1:0] shifted;
        logic [CMD_W-1:0] cmd;
        logic [CMD_W-1:0] fired;
        logic [63:0]      acc;
        logic [PROB_W-1:0] shown;
        shifted = cmd_map >> (3 * cls);
        cmd = shifted[CMD_W-1:0];
        if (cmd > CMD_MAX)
        begin
            cmd = CMD_NONE;
        end
        fired = CMD_NONE;
        shown = '0;
        if (cmd == CMD_NONE)
        begin
            run_count = 0;
            avg_conf = '0;
        end
        else
        begin
            if (cls != last_class)
            begin
                last_class = cls;
                run_count = 0;
                avg_conf = '0;
            end
            if (run_count < 255)
            begin
                run_count++;
            end
            acc = 64'(mix_alpha) * 64'(prob) + (64'd65536 - 64'(mix_alpha)) * 64'(avg_conf);
            avg_conf = acc[31:16];
            shown = avg_conf;
            if (run_count >= int'(run_needed) && avg_conf >= fire_level)
            begin
                run_count = -int'(lockout_len);
                avg_conf = '0;
                fired = cmd;
            end
        end
        if (fired != CMD_NONE)
        begin
            quiet_count = '0;
            rep.kind = KIND_FIRE;
        end
        else
        begin
            quiet_count = quiet_count + 8'd1;
            if (quiet_count >= report_every)
            begin
                quiet_count = '0;
                rep.kind = KIND_IDLE;
            end
            else
            begin
                rep.kind = KIND_NONE;
            end
        end
        rep.fired = fired;
        rep.top = cmd;
        rep.conf = shown;
        rep.lock = (run_count < 0);
        return rep;
    endfunction

    function automatic stim_row_t block_row(
        input logic [CLASS_W-1:0] cls,
        input logic [PROB_W-1:0]  prob
    );
        stim_row_t row;
        row = '0;
        row.op = ROW_BLOCK;
        row.cls = cls;
        row.prob = prob;
        return row;
    endfunction

    function automatic stim_row_t known_row(
        input logic [CLASS_W-1:0] cls,
        input logic [PROB_W-1:0]  prob,
        input report_kind_t       kind,
        input logic [CMD_W-1:0]   fired,
        input logic [CMD_W-1:0]   top,
        input logic [PROB_W-1:0]  conf,
        input logic               lock
    );
        stim_row_t row;
        row = block_row(cls, prob);
        row.typed = 1'b1;
        row.want = '{kind, fired, top, conf, lock};
        return row;
    endfunction

    function automatic stim_row_t setup_row(
        input logic [CFG_IDX_W-1:0]  idx,
        input logic [CFG_DATA_W-1:0] val
    );
        stim_row_t row;
        row = '0;
        row.op = ROW_SETUP;
        row.reg_index = idx;
        row.reg_value = val;
        return row;
    endfunction

    function automatic logic [PROB_W-1:0] strong_prob();
        case ($urandom_range(0, 7))
            0: return 16'd0;
            1: return 16'hFFFF;
            2, 3: return 16'($urandom_range(0, 65535));
            default: return 16'($urandom_range(40000, 65535));
        endcase
    endfunction

    task automatic note_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
        mismatches++;
        if (mismatches <= PRINT_CAP)
        begin
            $display("mismatch %s: got %0d expected %0d at %0t", what, got, exp_val, $time);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        case (idx)
            REG_CLASS_MAP:  cmd_map = val;
            REG_EMA_ALPHA:  mix_alpha = val[PROB_W-1:0];
            REG_THRESHOLD:  fire_level = val[PROB_W-1:0];
            REG_ROW_BLOCKS: run_needed = val[CNT_W-1:0];
            REG_LOCKOUT:    lockout_len = val[CNT_W-1:0];
            REG_IDLE_EVERY: report_every = val[CNT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic offer_block(
        input logic [CLASS_W-1:0] cls,
        input logic [PROB_W-1:0]  prob,
        input logic               typed,
        input block_report_t      typed_want
    );
        block_report_t rep;
        cfg_write <= 1'b0;
        while ($urandom_range(0, 99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        class_index <= cls;
        class_probability <= prob;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        rep = smooth_block(cls, prob);
        expected_reports.push_back(typed ? typed_want : rep);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (expected_reports.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic random_setup();
        logic [CFG_DATA_W-1:0] map;
        int                    k;
        if ($urandom_range(0, 3) == 0)
        begin
            map = CFG_DATA_W'({$urandom, $urandom});
        end
        else
        begin
            for (k = 0; k < 16; k++)
            begin
                map[3*k +: 3] = 3'($urandom_range(0, 4));
            end
        end
        write_reg(REG_CLASS_MAP, map);
        case ($urandom_range(0, 5))
            0: write_reg(REG_EMA_ALPHA, 48'd0);
            1: write_reg(REG_EMA_ALPHA, 48'hFFFF);
            default: write_reg(REG_EMA_ALPHA, 48'($urandom_range(6000, 40000)));
        endcase
        case ($urandom_range(0, 5))
            0: write_reg(REG_THRESHOLD, 48'd0);
            1: write_reg(REG_THRESHOLD, 48'hFFFF);
            default: write_reg(REG_THRESHOLD, 48'($urandom_range(30000, 62000)));
        endcase
        case ($urandom_range(0, 6))
            0: write_reg(REG_ROW_BLOCKS, 48'd0);
            1: write_reg(REG_ROW_BLOCKS, 48'd1);
            2: write_reg(REG_ROW_BLOCKS, 48'd255);
            default: write_reg(REG_ROW_BLOCKS, 48'($urandom_range(1, 12)));
        endcase
        case ($urandom_range(0, 5))
            0: write_reg(REG_LOCKOUT, 48'd0);
            1: write_reg(REG_LOCKOUT, 48'd255);
            default: write_reg(REG_LOCKOUT, 48'($urandom_range(1, 15)));
        endcase
        case ($urandom_range(0, 6))
            0: write_reg(REG_IDLE_EVERY, 48'd0);
            1: write_reg(REG_IDLE_EVERY, 48'd1);
            2: write_reg(REG_IDLE_EVERY, 48'd255);
            default: write_reg(REG_IDLE_EVERY, 48'($urandom_range(1, 40)));
        endcase
        write_reg($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO,
                  CFG_DATA_W'({$urandom, $urandom}));
    endtask

    task automatic random_blocks(input int count);
        int                 sent;
        int                 run;
        int                 top_len;
        int                 k;
        logic [CLASS_W-1:0] cls;
        sent = 0;
        while (sent < count)
        begin
            cls = 4'($urandom_range(0, 15));
            case ($urandom_range(0, 9))
                7:
                begin
                    offer_block(cls, strong_prob(), 1'b0, '0);
                    offer_block(cls ^ 4'($urandom_range(1, 15)), strong_prob(), 1'b0, '0);
                    sent += 2;
                end
                8, 9:
                begin
                    offer_block(cls, 16'($urandom_range(0, 65535)), 1'b0, '0);
                    sent++;
                end
                default:
                begin
                    top_len = (run_needed > 20) ? 24 : int'(run_needed) + 6;
                    run = $urandom_range(1, top_len);
                    for (k = 0; k < run; k++)
                    begin
                        offer_block(cls, strong_prob(), 1'b0, '0);
                    end
                    sent += run;
                end
            endcase
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    initial
    begin
        #(CLK_PERIOD * WATCHDOG_CYCLES);
        $display("keyword_posterior_smoother regression: fail");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_reports.size() == 0)
            begin
                note_mismatch("result beat with nothing pending", 32'(report_kind), 0);
            end
            else
            begin
                want = expected_reports.pop_front();
                if (report_kind !== want.kind)
                    note_mismatch("report_kind", 32'(report_kind), 32'(want.kind));
                if (fired_command !== want.fired)
                    note_mismatch("fired_command", 32'(fired_command), 32'(want.fired));
                if (top_command !== want.top)
                    note_mismatch("top_command", 32'(top_command), 32'(want.top));
                if (smoothed_confidence !== want.conf)
                    note_mismatch("smoothed_confidence", 32'(smoothed_confidence),
                                  32'(want.conf));
                if (in_lockout !== want.lock)
                    note_mismatch("in_lockout", 32'(in_lockout), 32'(want.lock));
            end
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_stall <= 1'b1;
        end
        else if (long_hold_req)
        begin
            long_hold_req = 1'b0;
            hold_left = LONG_HOLD;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(0, 99) < drain_stall_pct);
        end
    end

    initial
    begin
        int mode;
        int phase;
        int k;
        rst_n = 1'b0;
        in_valid = 1'b0;
        class_index = '0;
        class_probability = '0;
        out_stall = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        mismatches = 0;
        hold_left = 0;
        long_hold_req = 1'b0;
        blocks_open = 1'b0;
        send_gap_pct = 0;
        drain_stall_pct = 0;
        cmd_map = MAP_RESET;
        mix_alpha = ALPHA_RESET;
        fire_level = THRESHOLD_RESET;
        run_needed = ROW_RESET;
        lockout_len = LOCKOUT_RESET;
        report_every = IDLE_RESET;
        last_class = '0;
        run_count = 0;
        avg_conf = '0;
        quiet_count = '0;

        directed_rows = '{
            known_row(4'd0, 16'd0, KIND_NONE, CMD_NONE, CMD_NONE, 16'd0, 1'b0),
            known_row(4'd15, 16'hFFFF, KIND_NONE, CMD_NONE, CMD_NONE, 16'd0, 1'b0),
            known_row(4'd9, 16'h8000, KIND_NONE, CMD_NONE, CMD_NONE, 16'd0, 1'b0),
            setup_row(REG_CLASS_MAP, MAP_ALL_SET),
            known_row(4'd7, 16'hFFFF, KIND_NONE, CMD_NONE, CMD_NONE, 16'd0, 1'b0),
            setup_row(REG_CLASS_MAP, MAP_MIXED),
            setup_row(REG_EMA_ALPHA, 48'hFFFF),
            setup_row(REG_THRESHOLD, 48'hFFFF),
            setup_row(REG_ROW_BLOCKS, 48'd1),
            setup_row(REG_LOCKOUT, 48'd3),
            setup_row(REG_IDLE_EVERY, 48'd3),
            setup_row(REG_SPARE_LO, MAP_ALL_SET),
            setup_row(REG_SPARE_HI, 48'h5555_5555_5555),
            block_row(4'd1, 16'hFFFF),
            block_row(4'd1, 16'hFFFF),
            block_row(4'd5, 16'hFFFF),
            block_row(4'd6, 16'd1),
            block_row(4'd15, 16'hFFFF),
            block_row(4'd11, 16'd0),
            setup_row(REG_THRESHOLD, 48'd0),
            setup_row(REG_EMA_ALPHA, 48'd0),
            setup_row(REG_ROW_BLOCKS, 48'd0),
            setup_row(REG_LOCKOUT, 48'd0),
            setup_row(REG_IDLE_EVERY, 48'd0),
            known_row(4'd2, 16'd1234, KIND_FIRE, 3'd2, 3'd2, 16'd0, 1'b0),
            known_row(4'd2, 16'hFFFF, KIND_FIRE, 3'd2, 3'd2, 16'd0, 1'b0),
            known_row(4'd0, 16'hFFFF, KIND_IDLE, CMD_NONE, CMD_NONE, 16'd0, 1'b0),
            setup_row(REG_LOCKOUT, 48'd255),
            setup_row(REG_ROW_BLOCKS, 48'd1),
            setup_row(REG_EMA_ALPHA, 48'h8000),
            block_row(4'd3, 16'd40000),
            block_row(4'd3, 16'd40000),
            block_row(4'd4, 16'hFFFF),
            block_row(4'd12, 16'd0),
            setup_row(REG_THRESHOLD, 48'hFFFF),
            setup_row(REG_ROW_BLOCKS, 48'd255),
            setup_row(REG_EMA_ALPHA, 48'hFFFF),
            block_row(4'd8, 16'hFFFF),
            block_row(4'd8, 16'd0),
            block_row(4'd10, 16'hFFFF)
        };

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_gap_pct = 31;
        drain_stall_pct = 84;
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].op == ROW_SETUP)
            begin
                if (blocks_open)
                begin
                    settle();
                    blocks_open = 1'b0;
                end
                write_reg(directed_rows[i].reg_index, directed_rows[i].reg_value);
            end
            else
            begin
                offer_block(directed_rows[i].cls, directed_rows[i].prob,
                            directed_rows[i].typed, directed_rows[i].want);
                blocks_open = 1'b1;
            end
        end

        for (mode = 0; mode < 3; mode++)
        begin
            case (mode)
                0:
                begin
                    send_gap_pct = 31;
                    drain_stall_pct = 84;
                end
                1:
                begin
                    send_gap_pct = 84;
                    drain_stall_pct = 31;
                end
                default:
                begin
                    send_gap_pct = 0;
                    drain_stall_pct = 0;
                end
            endcase
            for (phase = 0; phase < 3; phase++)
            begin
                settle();
                if (mode == 2 && phase == 1)
                begin
                    // hold the class long enough for the row count to pin at its top
                    write_reg(REG_CLASS_MAP, MAP_ALL_RIGHT);
                    write_reg(REG_EMA_ALPHA, 48'hFFFF);
                    write_reg(REG_THRESHOLD, 48'hFFFF);
                    write_reg(REG_ROW_BLOCKS, 48'd255);
                    write_reg(REG_LOCKOUT, 48'($urandom_range(0, 255)));
                    write_reg(REG_IDLE_EVERY, 48'd255);
                    for (k = 0; k < 280; k++)
                    begin
                        offer_block(4'd7, 16'hFFFF, 1'b0, '0);
                    end
                end
                else
                begin
                    random_setup();
                    if (mode == 0 && phase == 1)
                    begin
                        long_hold_req = 1'b1;
                    end
                    random_blocks(105);
                end
            end
        end

        settle();
        repeat (4) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("keyword_posterior_smoother regression: pass");
        end
        else
        begin
            $display("keyword_posterior_smoother regression: fail");
        end
        $finish;
    end

endmodule
